// ===== hw/rtl/ecpa_pkg.sv =====
package ecpa_pkg;

   localparam int MODULUS_RESET = 67;

   // shared arithmetic unit operations
   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_INV
   } alu_op_type;

   // operand registers of the sequencer, SRC_ONE is the constant one
   typedef enum logic [2:0] {
      SRC_X1,
      SRC_Y1,
      SRC_X2,
      SRC_Y2,
      SRC_T0,
      SRC_T1,
      SRC_C,
      SRC_ONE
   } src_type;

   typedef enum logic [1:0] {
      GO_NEXT,
      GO_CLASSIFY,
      GO_FINISH
   } exit_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctl_type;

   typedef struct packed {
      logic done;
      logic ok;
   } alu_sts_type;

   typedef struct packed {
      logic idle;
      logic done;
   } seq_sts_type;

   localparam int PC_BITS  = 5;
   localparam int PROG_LEN = 20;

   typedef logic [PC_BITS-1:0] pc_type;

   localparam pc_type PC_REDUCE = pc_type'(0);
   localparam pc_type PC_DBL    = pc_type'(4);
   localparam pc_type PC_TAIL   = pc_type'(10);
   localparam pc_type PC_CHORD  = pc_type'(16);

   typedef struct packed {
      alu_op_type op;
      src_type    dst;
      src_type    src_a;
      src_type    src_b;
      pc_type     nxt;
      exit_type   exit_to;
   } ucode_type;

   // dst = op(src_a, src_b); the multiplier scans src_b bit by bit
   localparam ucode_type PROG [PROG_LEN] = '{
      // reduce the four coordinates: 1 * v mod m
      '{OP_MUL, SRC_X1, SRC_ONE, SRC_X1, pc_type'(1),  GO_NEXT},
      '{OP_MUL, SRC_Y1, SRC_ONE, SRC_Y1, pc_type'(2),  GO_NEXT},
      '{OP_MUL, SRC_X2, SRC_ONE, SRC_X2, pc_type'(3),  GO_NEXT},
      '{OP_MUL, SRC_Y2, SRC_ONE, SRC_Y2, PC_DBL,       GO_CLASSIFY},
      // doubling slope 3x^2 / 2y
      '{OP_MUL, SRC_T0, SRC_X1,  SRC_X1, pc_type'(5),  GO_NEXT},
      '{OP_ADD, SRC_T1, SRC_T0,  SRC_T0, pc_type'(6),  GO_NEXT},
      '{OP_ADD, SRC_T0, SRC_T1,  SRC_T0, pc_type'(7),  GO_NEXT},
      '{OP_ADD, SRC_T1, SRC_Y1,  SRC_Y1, pc_type'(8),  GO_NEXT},
      '{OP_INV, SRC_T1, SRC_T1,  SRC_ONE, pc_type'(9), GO_NEXT},
      '{OP_MUL, SRC_C,  SRC_T0,  SRC_T1, PC_TAIL,      GO_NEXT},
      // common tail: rx = c^2 - x1 - x2, ry = c (x1 - rx) - y1
      '{OP_MUL, SRC_T0, SRC_C,   SRC_C,  pc_type'(11), GO_NEXT},
      '{OP_SUB, SRC_T0, SRC_T0,  SRC_X1, pc_type'(12), GO_NEXT},
      '{OP_SUB, SRC_T0, SRC_T0,  SRC_X2, pc_type'(13), GO_NEXT},
      '{OP_SUB, SRC_T1, SRC_X1,  SRC_T0, pc_type'(14), GO_NEXT},
      '{OP_MUL, SRC_T1, SRC_C,   SRC_T1, pc_type'(15), GO_NEXT},
      '{OP_SUB, SRC_T1, SRC_T1,  SRC_Y1, PC_REDUCE,    GO_FINISH},
      // chord slope (y2 - y1) / (x2 - x1)
      '{OP_SUB, SRC_T0, SRC_Y2,  SRC_Y1, pc_type'(17), GO_NEXT},
      '{OP_SUB, SRC_T1, SRC_X2,  SRC_X1, pc_type'(18), GO_NEXT},
      '{OP_INV, SRC_T1, SRC_T1,  SRC_ONE, pc_type'(19), GO_NEXT},
      '{OP_MUL, SRC_C,  SRC_T0,  SRC_T1, PC_TAIL,      GO_NEXT}
   };

endpackage

// ===== hw/rtl/ecpa_if.sv =====
interface ecpa_req_if #(parameter int COORD_BITS = 16);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] first_x;
   logic [COORD_BITS-1:0] first_y;
   logic [COORD_BITS-1:0] second_x;
   logic [COORD_BITS-1:0] second_y;

   modport source (output valid, first_x, first_y, second_x, second_y, input ready);
   modport sink (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

interface ecpa_rsp_if #(parameter int COORD_BITS = 16);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] sum_x;
   logic [COORD_BITS-1:0] sum_y;

   modport source (output valid, sum_x, sum_y, input ready);
   modport sink (input valid, sum_x, sum_y, output ready);
endinterface

interface ecpa_csr_if #(parameter int COORD_BITS = 16);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] modulus;

   modport source (output valid, modulus, input ready);
   modport sink (input valid, modulus, output ready);
endinterface

// ===== hw/rtl/ecpa_alu.sv =====
module ecpa_alu import ecpa_pkg::*; #(
   parameter int COORD_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  alu_ctl_type           ctl,
   input  logic [COORD_BITS-1:0] opa,
   input  logic [COORD_BITS-1:0] opb,
   input  logic [COORD_BITS-1:0] modulus,
   output alu_sts_type           sts,
   output logic [COORD_BITS-1:0] result
);

   localparam int N  = COORD_BITS;
   localparam int TW = COORD_BITS + 3;
   localparam int KW = $clog2(COORD_BITS);

   typedef enum logic [4:0] {
      A_IDLE  = 5'b00001,
      A_MUL   = 5'b00010,
      A_CHECK = 5'b00100,
      A_UP    = 5'b01000,
      A_DOWN  = 5'b10000
   } alu_state_type;

   alu_state_type state_ff, state_in;
   logic                 done_ff, done_in;
   logic                 ok_ff, ok_in;
   logic [N-1:0]         res_ff, res_in;
   logic [KW-1:0]        k_ff, k_in;
   // multiplier
   logic [N-1:0]         acc_ff, acc_in;
   logic [N-1:0]         mcand_ff, mcand_in;
   logic [N-1:0]         mplier_ff, mplier_in;
   // extended Euclid
   logic [N-1:0]         r_ff, r_in;
   logic [N-1:0]         nr_ff, nr_in;
   logic [N-1:0]         d_ff, d_in;
   logic [N-1:0]         rem_ff, rem_in;
   logic signed [TW-1:0] t_ff, t_in;
   logic signed [TW-1:0] nt_ff, nt_in;
   logic signed [TW-1:0] snt_ff, snt_in;
   logic signed [TW-1:0] tacc_ff, tacc_in;

   logic [N+1:0]         mul_sum, mul_wide, m_once, m_twice;
   logic [N-1:0]         mul_red;
   logic [N:0]           add_sum, add_wide, sub_wide;
   logic                 up_fits, down_fits;
   logic [N-1:0]         rem_nx;
   logic signed [TW-1:0] tacc_nx, m_signed, t_fix;

   // shift-add step: acc = 2 acc + bit * mcand, reduced below m
   always_comb begin
      m_once  = {2'b00, modulus};
      m_twice = {1'b0, modulus, 1'b0};
      mul_sum = {1'b0, acc_ff, 1'b0} + (mplier_ff[N-1] ? {2'b00, mcand_ff} : '0);
      if (mul_sum >= m_twice) begin
         mul_wide = mul_sum - m_twice;
      end else if (mul_sum >= m_once) begin
         mul_wide = mul_sum - m_once;
      end else begin
         mul_wide = mul_sum;
      end
      mul_red = mul_wide[N-1:0];
   end

   always_comb begin
      add_sum  = {1'b0, opa} + {1'b0, opb};
      add_wide = (add_sum >= {1'b0, modulus}) ? add_sum - {1'b0, modulus} : add_sum;
      sub_wide = (opa >= opb) ? {1'b0, opa} - {1'b0, opb}
                              : {1'b0, opa} + {1'b0, modulus} - {1'b0, opb};
   end

   always_comb begin
      up_fits   = {d_ff, 1'b0} <= {1'b0, rem_ff};
      down_fits = d_ff <= rem_ff;
      rem_nx    = down_fits ? rem_ff - d_ff : rem_ff;
      tacc_nx   = down_fits ? tacc_ff - snt_ff : tacc_ff;
      m_signed  = signed'({3'b000, modulus});
      t_fix     = t_ff[TW-1] ? t_ff + m_signed : t_ff;
   end

   always_comb begin
      state_in  = state_ff;
      done_in   = 1'b0;
      ok_in     = ok_ff;
      res_in    = res_ff;
      k_in      = k_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      r_in      = r_ff;
      nr_in     = nr_ff;
      d_in      = d_ff;
      rem_in    = rem_ff;
      t_in      = t_ff;
      nt_in     = nt_ff;
      snt_in    = snt_ff;
      tacc_in   = tacc_ff;
      unique case (state_ff)
         A_IDLE: begin
            if (ctl.start) begin
               unique case (ctl.op)
                  OP_ADD: begin
                     res_in  = add_wide[N-1:0];
                     ok_in   = 1'b1;
                     done_in = 1'b1;
                  end
                  OP_SUB: begin
                     res_in  = sub_wide[N-1:0];
                     ok_in   = 1'b1;
                     done_in = 1'b1;
                  end
                  OP_MUL: begin
                     acc_in    = '0;
                     mcand_in  = opa;
                     mplier_in = opb;
                     k_in      = KW'(COORD_BITS - 1);
                     state_in  = A_MUL;
                  end
                  OP_INV: begin
                     r_in     = modulus;
                     nr_in    = opa;
                     t_in     = '0;
                     nt_in    = signed'(TW'(1));
                     state_in = A_CHECK;
                  end
               endcase
            end
         end
         A_MUL: begin
            acc_in    = mul_red;
            mplier_in = {mplier_ff[N-2:0], 1'b0};
            if (k_ff == '0) begin
               res_in   = mul_red;
               ok_in    = 1'b1;
               done_in  = 1'b1;
               state_in = A_IDLE;
            end else begin
               k_in = k_ff - KW'(1);
            end
         end
         A_CHECK: begin
            if (nr_ff == '0) begin
               // gcd is r: an inverse exists only when it is one
               res_in   = t_fix[N-1:0];
               ok_in    = (r_ff == COORD_BITS'(1));
               done_in  = 1'b1;
               state_in = A_IDLE;
            end else begin
               d_in     = nr_ff;
               snt_in   = nt_ff;
               rem_in   = r_ff;
               tacc_in  = t_ff;
               k_in     = '0;
               state_in = A_UP;
            end
         end
         A_UP: begin
            // align the divisor to the top of the remainder
            if (up_fits) begin
               d_in   = {d_ff[N-2:0], 1'b0};
               snt_in = snt_ff <<< 1;
               k_in   = k_ff + KW'(1);
            end else begin
               state_in = A_DOWN;
            end
         end
         A_DOWN: begin
            rem_in  = rem_nx;
            tacc_in = tacc_nx;
            if (k_ff == '0) begin
               r_in     = nr_ff;
               nr_in    = rem_nx;
               t_in     = nt_ff;
               nt_in    = tacc_nx;
               state_in = A_CHECK;
            end else begin
               d_in   = {1'b0, d_ff[N-1:1]};
               snt_in = snt_ff >>> 1;
               k_in   = k_ff - KW'(1);
            end
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff     <= ok_in;
      res_ff    <= res_in;
      k_ff      <= k_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      r_ff      <= r_in;
      nr_ff     <= nr_in;
      d_ff      <= d_in;
      rem_ff    <= rem_in;
      t_ff      <= t_in;
      nt_ff     <= nt_in;
      snt_ff    <= snt_in;
      tacc_ff   <= tacc_in;
   end

   assign sts.done = done_ff;
   assign sts.ok   = ok_ff;
   assign result   = res_ff;

endmodule

// ===== hw/rtl/ecpa_seq.sv =====
module ecpa_seq import ecpa_pkg::*; #(
   parameter int COORD_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COORD_BITS-1:0] in_x1,
   input  logic [COORD_BITS-1:0] in_y1,
   input  logic [COORD_BITS-1:0] in_x2,
   input  logic [COORD_BITS-1:0] in_y2,
   input  logic [COORD_BITS-1:0] modulus,
   input  logic                  out_free,
   output alu_ctl_type           alu_ctl,
   output logic [COORD_BITS-1:0] alu_opa,
   output logic [COORD_BITS-1:0] alu_opb,
   input  alu_sts_type           alu_sts,
   input  logic [COORD_BITS-1:0] alu_result,
   output seq_sts_type           sts,
   output logic [COORD_BITS-1:0] sum_x,
   output logic [COORD_BITS-1:0] sum_y
);

   localparam int N = COORD_BITS;

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_ISSUE    = 5'b00010,
      S_WAIT     = 5'b00100,
      S_CLASSIFY = 5'b01000,
      S_FINISH   = 5'b10000
   } seq_state_type;

   seq_state_type state_ff, state_in;
   pc_type        pc_ff, pc_in;
   logic [N-1:0]  x1_ff, x1_in, y1_ff, y1_in, x2_ff, x2_in, y2_ff, y2_in;
   logic [N-1:0]  t0_ff, t0_in, t1_ff, t1_in, c_ff, c_in;
   logic [N-1:0]  sx_ff, sx_in, sy_ff, sy_in;
   ucode_type     uop;
   logic          first_inf, second_inf;

   assign uop        = PROG[pc_ff];
   assign first_inf  = (x1_ff == '0) && (y1_ff == '0);
   assign second_inf = (x2_ff == '0) && (y2_ff == '0);

   always_comb begin
      unique case (uop.src_a)
         SRC_X1:  alu_opa = x1_ff;
         SRC_Y1:  alu_opa = y1_ff;
         SRC_X2:  alu_opa = x2_ff;
         SRC_Y2:  alu_opa = y2_ff;
         SRC_T0:  alu_opa = t0_ff;
         SRC_T1:  alu_opa = t1_ff;
         SRC_C:   alu_opa = c_ff;
         SRC_ONE: alu_opa = N'(1);
      endcase
      unique case (uop.src_b)
         SRC_X1:  alu_opb = x1_ff;
         SRC_Y1:  alu_opb = y1_ff;
         SRC_X2:  alu_opb = x2_ff;
         SRC_Y2:  alu_opb = y2_ff;
         SRC_T0:  alu_opb = t0_ff;
         SRC_T1:  alu_opb = t1_ff;
         SRC_C:   alu_opb = c_ff;
         SRC_ONE: alu_opb = N'(1);
      endcase
   end

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      x1_in    = x1_ff;
      y1_in    = y1_ff;
      x2_in    = x2_ff;
      y2_in    = y2_ff;
      t0_in    = t0_ff;
      t1_in    = t1_ff;
      c_in     = c_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (modulus < N'(2)) begin
                  sx_in    = '0;
                  sy_in    = '0;
                  state_in = S_FINISH;
               end else begin
                  x1_in    = in_x1;
                  y1_in    = in_y1;
                  x2_in    = in_x2;
                  y2_in    = in_y2;
                  pc_in    = PC_REDUCE;
                  state_in = S_ISSUE;
               end
            end
         end
         S_ISSUE: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (alu_sts.done) begin
               if (!alu_sts.ok) begin
                  // no inverse: the sum is the point at infinity
                  sx_in    = '0;
                  sy_in    = '0;
                  state_in = S_FINISH;
               end else begin
                  unique case (uop.dst)
                     SRC_X1:  x1_in = alu_result;
                     SRC_Y1:  y1_in = alu_result;
                     SRC_X2:  x2_in = alu_result;
                     SRC_Y2:  y2_in = alu_result;
                     SRC_T0:  t0_in = alu_result;
                     SRC_T1:  t1_in = alu_result;
                     SRC_C:   c_in  = alu_result;
                     SRC_ONE: c_in  = c_ff;
                  endcase
                  unique case (uop.exit_to)
                     GO_NEXT: begin
                        pc_in    = uop.nxt;
                        state_in = S_ISSUE;
                     end
                     GO_CLASSIFY: begin
                        state_in = S_CLASSIFY;
                     end
                     GO_FINISH: begin
                        sx_in    = t0_ff;
                        sy_in    = alu_result;
                        state_in = S_FINISH;
                     end
                     default: begin
                        state_in = S_IDLE;
                     end
                  endcase
               end
            end
         end
         S_CLASSIFY: begin
            // identity checks take precedence over the equality test
            priority if (first_inf) begin
               sx_in    = x2_ff;
               sy_in    = y2_ff;
               state_in = S_FINISH;
            end else if (second_inf) begin
               sx_in    = x1_ff;
               sy_in    = y1_ff;
               state_in = S_FINISH;
            end else if ((x1_ff == x2_ff) && (y1_ff == y2_ff)) begin
               pc_in    = PC_DBL;
               state_in = S_ISSUE;
            end else if (x1_ff == x2_ff) begin
               sx_in    = '0;
               sy_in    = '0;
               state_in = S_FINISH;
            end else begin
               pc_in    = PC_CHORD;
               state_in = S_ISSUE;
            end
         end
         S_FINISH: begin
            // hold until the output register can take the transaction
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      pc_ff <= pc_in;
      x1_ff <= x1_in;
      y1_ff <= y1_in;
      x2_ff <= x2_in;
      y2_ff <= y2_in;
      t0_ff <= t0_in;
      t1_ff <= t1_in;
      c_ff  <= c_in;
      sx_ff <= sx_in;
      sy_ff <= sy_in;
   end

   assign alu_ctl.start = (state_ff == S_ISSUE);
   assign alu_ctl.op    = uop.op;
   assign sts.idle      = (state_ff == S_IDLE);
   assign sts.done      = (state_ff == S_FINISH) && out_free;
   assign sum_x         = sx_ff;
   assign sum_y         = sy_ff;

endmodule

// ===== hw/rtl/ec_affine_point_add_unit.sv =====
// Affine point addition on y^2 = x^3 + b over GF(modulus), (0,0) standing for infinity.
// One transaction at a time: req_bus.ready is high only while the unit is idle, and the
// sum waits in an output register so the next transaction can be taken before rsp_bus
// drains it. Coordinates are first reduced modulo the modulus register, which costs four
// passes of the bit-serial multiplier; the identity and vertical-line cases finish there.
// A doubling then runs four more multiplies and seven add/subtract steps, and a chord add
// one multiply and one step fewer, plus the modular inverse, done by shift-subtract
// extended Euclid. A modulus below two gives (0,0). The multiplier and the Euclid loop
// share one arithmetic unit under a microcoded sequencer. Write the modulus only while
// the unit is idle.
module ec_affine_point_add_unit import ecpa_pkg::*; #(
   parameter int COORD_BITS = 16
) (
   input logic          clock,
   input logic          reset,
   ecpa_req_if.sink     req_bus,
   ecpa_rsp_if.source   rsp_bus,
   ecpa_csr_if.sink     csr_bus
);

   logic [COORD_BITS-1:0] modulus_ff, modulus_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] rsp_x_ff, rsp_x_in;
   logic [COORD_BITS-1:0] rsp_y_ff, rsp_y_in;

   alu_ctl_type           alu_ctl;
   alu_sts_type           alu_sts;
   seq_sts_type           seq_sts;
   logic [COORD_BITS-1:0] alu_opa, alu_opb, alu_result;
   logic [COORD_BITS-1:0] seq_x, seq_y;
   logic                  req_take, out_free;

   assign req_take = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   ecpa_seq #(
      .COORD_BITS(COORD_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (req_take),
      .in_x1      (req_bus.first_x),
      .in_y1      (req_bus.first_y),
      .in_x2      (req_bus.second_x),
      .in_y2      (req_bus.second_y),
      .modulus    (modulus_ff),
      .out_free   (out_free),
      .alu_ctl    (alu_ctl),
      .alu_opa    (alu_opa),
      .alu_opb    (alu_opb),
      .alu_sts    (alu_sts),
      .alu_result (alu_result),
      .sts        (seq_sts),
      .sum_x      (seq_x),
      .sum_y      (seq_y)
   );

   ecpa_alu #(
      .COORD_BITS(COORD_BITS)
   ) u_alu (
      .clock   (clock),
      .reset   (reset),
      .ctl     (alu_ctl),
      .opa     (alu_opa),
      .opb     (alu_opb),
      .modulus (modulus_ff),
      .sts     (alu_sts),
      .result  (alu_result)
   );

   always_comb begin
      modulus_in   = modulus_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      if (csr_bus.valid) begin
         modulus_in = csr_bus.modulus;
      end
      if (seq_sts.done) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = seq_x;
         rsp_y_in     = seq_y;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= COORD_BITS'(MODULUS_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
   end

   assign req_bus.ready = seq_sts.idle;
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.sum_x = rsp_x_ff;
   assign rsp_bus.sum_y = rsp_y_ff;

`ifndef SYNTHESIS
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_bus.ready)
      else $error("unit took a transaction while still busy");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |-> !seq_sts.done)
      else $error("result overwrote a pending transaction");

   a_alu_only_busy: assert property (@(posedge clock) disable iff (reset)
      alu_sts.done |-> !seq_sts.idle)
      else $error("arithmetic unit finished with no transaction in flight");
`endif

endmodule

// ===== tb/ec_affine_point_add_unit_tb.sv =====
module ec_affine_point_add_unit_tb;
   import ecpa_pkg::MODULUS_RESET;

   localparam int          CB          = 16;
   localparam int unsigned MAX_COORD   = (1 << CB) - 1;
   localparam int          CYCLE_LIMIT = 1_500_000;
   localparam int          SETTLE      = 300;
   localparam int          NO_DRAIN    = -1;

   typedef struct {
      logic [CB-1:0] first_x;
      logic [CB-1:0] first_y;
      logic [CB-1:0] second_x;
      logic [CB-1:0] second_y;
      bit            drain_first;
   } point_pair_type;

   typedef struct packed {
      logic [CB-1:0] sum_x;
      logic [CB-1:0] sum_y;
   } sum_point_type;

   logic clock = 1'b0;
   logic reset;

   ecpa_req_if #(.COORD_BITS(CB)) req_bus ();
   ecpa_rsp_if #(.COORD_BITS(CB)) rsp_bus ();
   ecpa_csr_if #(.COORD_BITS(CB)) csr_bus ();

   ec_affine_point_add_unit #(.COORD_BITS(CB)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   point_pair_type pending_adds[$];
   sum_point_type  expected_sums[$];
   logic [CB-1:0]  field_modulus = CB'(MODULUS_RESET);
   int unsigned    send_idle_pct = 0;
   int unsigned    recv_stall_pct = 0;
   int unsigned    mismatches = 0;
   int unsigned    cycle_count = 0;
   logic           req_taken = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Affine sum of two points over GF(m); (0,0) is the point at infinity.
   function automatic sum_point_type predict_sum(input logic [CB-1:0] fx, fy, sx, sy,
                                                 input logic [CB-1:0] modulus_value);
      longint        m, x1, y1, x2, y2, num, den, slope, rx, ry;
      longint        r, nr, t, nt, q, tmp;
      sum_point_type res;
      res = '0;
      m   = modulus_value;
      if (m < 2)
         return res;
      x1 = fx % m;
      y1 = fy % m;
      x2 = sx % m;
      y2 = sy % m;
      if (x1 == 0 && y1 == 0) begin
         res.sum_x = x2[CB-1:0];
         res.sum_y = y2[CB-1:0];
         return res;
      end
      if (x2 == 0 && y2 == 0) begin
         res.sum_x = x1[CB-1:0];
         res.sum_y = y1[CB-1:0];
         return res;
      end
      if (x1 == x2 && y1 != y2)
         return res;
      if (x1 == x2) begin
         num = (3 * x1 * x1) % m;
         den = (2 * y1) % m;
      end else begin
         num = (y2 - y1 + m) % m;
         den = (x2 - x1 + m) % m;
      end
      if (den == 0)
         return res;
      // extended Euclid; no inverse when the gcd is not one
      t  = 0;
      nt = 1;
      r  = m;
      nr = den;
      while (nr != 0) begin
         q   = r / nr;
         tmp = t - q * nt;
         t   = nt;
         nt  = tmp;
         tmp = r - q * nr;
         r   = nr;
         nr  = tmp;
      end
      if (r != 1)
         return res;
      if (t < 0)
         t += m;
      slope = (num * t) % m;
      rx = ((slope * slope) % m - x1 - x2 + 2 * m) % m;
      ry = ((slope * ((x1 - rx + m) % m)) % m - y1 + m) % m;
      res.sum_x = rx[CB-1:0];
      res.sum_y = ry[CB-1:0];
      return res;
   endfunction

   function automatic int unsigned coord_below(int unsigned m);
      return $urandom_range(0, m - 1);
   endfunction

   // Add a random multiple of m now and then so the block has to reduce.
   function automatic logic [CB-1:0] lift(int unsigned v, int unsigned m);
      int unsigned k;
      if ($urandom_range(0, 3) != 0)
         return v[CB-1:0];
      k = $urandom_range(0, (MAX_COORD - v) / m);
      return CB'(v + k * m);
   endfunction

   function automatic point_pair_type random_pair(int unsigned m);
      int unsigned    kind, ax, ay, bx, by;
      point_pair_type p;
      kind = $urandom_range(0, 99);
      ax = coord_below(m);
      ay = coord_below(m);
      bx = coord_below(m);
      by = coord_below(m);
      if (kind < 8) begin
         ax = 0;
         ay = 0;
      end else if (kind < 16) begin
         bx = 0;
         by = 0;
      end else if (kind < 19) begin
         ax = 0;
         ay = 0;
         bx = 0;
         by = 0;
      end else if (kind < 40) begin
         bx = ax;
         by = ay;
      end else if (kind < 45) begin
         ay = 0;
         bx = ax;
         by = 0;
      end else if (kind < 55) begin
         bx = ax;
         by = (m - ay) % m;
      end
      if (kind >= 88) begin
         p.first_x  = CB'($urandom_range(0, MAX_COORD));
         p.first_y  = CB'($urandom_range(0, MAX_COORD));
         p.second_x = CB'($urandom_range(0, MAX_COORD));
         p.second_y = CB'($urandom_range(0, MAX_COORD));
      end else begin
         p.first_x  = lift(ax, m);
         p.first_y  = lift(ay, m);
         p.second_x = lift(bx, m);
         p.second_y = lift(by, m);
      end
      p.drain_first = 1'b0;
      return p;
   endfunction

   // Look past the falling edge so the driver's updates are visible.
   task automatic wait_drained();
      do begin
         @(negedge clock);
         #1;
      end while (pending_adds.size() != 0 || req_bus.valid || expected_sums.size() != 0);
   endtask

   // Call between a falling and the next rising edge with the block idle.
   task automatic write_modulus(logic [CB-1:0] value);
      csr_bus.valid   <= 1'b1;
      csr_bus.modulus <= value;
      do
         @(posedge clock);
      while (!(csr_bus.valid && csr_bus.ready));
      field_modulus = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic run_phase(int unsigned new_modulus, int unsigned idle_pct,
                            int unsigned stall_pct, int n_items, int drain_at);
      point_pair_type p;
      wait_drained();
      write_modulus(new_modulus[CB-1:0]);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < n_items; i++) begin
         p = random_pair(new_modulus);
         p.drain_first = (i == drain_at);
         pending_adds.push_back(p);
      end
      wait_drained();
   endtask

   task automatic note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("%s", msg);
   endtask

   // Request driver: hold the current transaction until it is taken.
   always @(negedge clock) begin : req_driver
      point_pair_type p;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (pending_adds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
             (!pending_adds[0].drain_first || expected_sums.size() == 0)) begin
            p = pending_adds.pop_front();
            req_bus.valid    <= 1'b1;
            req_bus.first_x  <= p.first_x;
            req_bus.first_y  <= p.first_y;
            req_bus.second_x <= p.second_x;
            req_bus.second_y <= p.second_y;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : sum_checker
      sum_point_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         // check results before queuing a new prediction on the same edge
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_sums.size() == 0) begin
               note_mismatch($sformatf("unexpected sum (%0d,%0d) with nothing pending",
                                       rsp_bus.sum_x, rsp_bus.sum_y));
            end else begin
               want = expected_sums.pop_front();
               if (rsp_bus.sum_x !== want.sum_x)
                  note_mismatch($sformatf("sum_x mismatch: expected %0d, got %0d",
                                          want.sum_x, rsp_bus.sum_x));
               if (rsp_bus.sum_y !== want.sum_y)
                  note_mismatch($sformatf("sum_y mismatch: expected %0d, got %0d",
                                          want.sum_y, rsp_bus.sum_y));
            end
         end
         req_taken <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready)
            expected_sums.push_back(predict_sum(req_bus.first_x, req_bus.first_y,
                                                req_bus.second_x, req_bus.second_y,
                                                field_modulus));
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      csr_bus.valid   = 1'b0;
      csr_bus.modulus = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed cases at the reset modulus of 67
      pending_adds.push_back('{16'd0, 16'd0, 16'd5, 16'd10, 1'b0});         // inf + P
      pending_adds.push_back('{16'd5, 16'd10, 16'd0, 16'd0, 1'b0});         // P + inf
      pending_adds.push_back('{16'd0, 16'd0, 16'd0, 16'd0, 1'b0});          // inf + inf
      pending_adds.push_back('{16'd5, 16'd10, 16'd5, 16'd10, 1'b0});        // doubling
      pending_adds.push_back('{16'd7, 16'd0, 16'd7, 16'd0, 1'b0});          // double, y zero
      pending_adds.push_back('{16'd5, 16'd10, 16'd5, 16'd57, 1'b0});        // P + (-P)
      pending_adds.push_back('{16'd5, 16'd10, 16'd5, 16'd11, 1'b0});        // vertical line
      pending_adds.push_back('{16'd5, 16'd10, 16'd20, 16'd30, 1'b0});       // chord
      pending_adds.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0});
      pending_adds.push_back('{16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 1'b0});
      pending_adds.push_back('{16'd67, 16'd134, 16'd3, 16'd4, 1'b0});       // reduces to inf
      pending_adds.push_back('{16'd3, 16'd4, 16'd134, 16'd201, 1'b0});      // 3,4 + 0,0 reduced
      pending_adds.push_back('{16'd3, 16'd4, 16'd70, 16'd71, 1'b0});        // equal once reduced
      pending_adds.push_back('{16'd66, 16'd66, 16'd133, 16'd200, 1'b0});
      pending_adds.push_back('{16'd0, 16'd5, 16'd0, 16'd62, 1'b0});         // x zero, not inf
      pending_adds.push_back('{16'd0, 16'd5, 16'd0, 16'd5, 1'b0});
      pending_adds.push_back('{16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA, 1'b0});
      pending_adds.push_back('{16'd1, 16'd0, 16'd0, 16'd1, 1'b0});
      pending_adds.push_back('{16'd1, 16'd1, 16'd2, 16'd2, 1'b0});
      pending_adds.push_back('{16'd66, 16'd1, 16'd65, 16'd66, 1'b0});

      run_phase(3, 0, 0, 60, NO_DRAIN);
      run_phase(65521, 59, 0, 160, 80);
      run_phase(65535, 0, 59, 140, NO_DRAIN);
      run_phase(97, 36, 36, 160, 40);
      run_phase(4, 59, 0, 60, NO_DRAIN);
      run_phase(8191, 0, 0, 160, NO_DRAIN);
      run_phase(251, 36, 36, 160, 100);

      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && expected_sums.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
